// File: sv/msync_pkg.sv
package msync_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SYNC_MODE   = 2'd0;
  localparam logic [1:0] REG_CLOCK_INT   = 2'd1;
  localparam logic [1:0] REG_TC_INT      = 2'd2;
  localparam logic [1:0] REG_FPS         = 2'd3;

  // sync modes
  localparam logic [1:0] MODE_CLOCK      = 2'd1;
  localparam logic [1:0] MODE_TIMECODE   = 2'd2;

  // reset values of the registers
  localparam logic [23:0] CLOCK_INT_RESET = 24'd1837;
  localparam logic [23:0] TC_INT_RESET    = 24'd3528;
  localparam logic [4:0]  FPS_RESET       = 5'd25;

  // midi status and data bytes
  localparam logic [7:0] ST_CLOCK        = 8'hF8;
  localparam logic [7:0] ST_QUARTER      = 8'hF1;
  localparam logic [7:0] ST_SYSEX        = 8'hF0;
  localparam logic [7:0] ST_EOX          = 8'hF7;
  localparam logic [7:0] SYSEX_ALL_CALL  = 8'h7F;
  localparam logic [7:0] SYSEX_MTC       = 8'h01;
  localparam logic [7:0] SYSEX_FULL      = 8'h01;

  // timecode wrap points
  localparam logic [5:0] SECS_PER_MIN    = 6'd60;
  localparam logic [5:0] MINS_PER_HOUR   = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY   = 5'd24;

  // remainder unit status
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

  // one outgoing message
  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic       data_one_present;
    logic [7:0] data_two;
    logic       data_two_present;
    logic       last_of_run;
  } msg_t;

endpackage

// File: sv/msync_mod_serial.sv
module msync_mod_serial #(
  parameter int PosW = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [PosW-1:0]            dividend,
  input  logic [23:0]                divisor,
  output msync_pkg::div_stat_t       stat
);
  import msync_pkg::*;

  localparam int CntW = $clog2(PosW);

  logic [PosW-1:0] shreg;
  logic [23:0]     dvsr;
  logic [23:0]     rem;
  logic [23:0]     rem_next;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [24:0]     trial;

  // one restoring step per cycle, dividend bits enter msb first
  always_comb begin
    trial = {rem, shreg[PosW-1]};
    if (trial >= {1'b0, dvsr}) begin
      rem_next = 24'(trial - {1'b0, dvsr});
    end else begin
      rem_next = trial[23:0];
    end
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CntW'(PosW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvsr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[PosW-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

// File: sv/midi_sync_generator_core.sv
// MIDI clock / timecode quarter-frame generator.
// Input channel (in_valid/in_ready): req_type selects a position tick or a
// rewind; frame_position is the transport position for a tick.
// Output channel (out_valid/out_ready): one MIDI message per transfer with
// up to two data bytes; last_of_run marks the final message of an input.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (sync mode, clock interval, timecode interval, frames per second).
// Items are processed one at a time. A tick in clock or timecode mode with a
// nonzero interval runs a bit-serial remainder of the position by the interval,
// one position bit per cycle, then, if the remainder is zero, emits its messages
// into the output register at one per cycle while the receiver keeps up. A rewind,
// or a tick in any other mode or with a zero interval, leaves the block idle
// (a rewind in timecode mode first emits the four full-frame messages).
// Reset restores the register defaults, clears the timecode counters and
// empties the output register. A stalled receiver holds the current message
// in the output register and the block waits; nothing is dropped.
module midi_sync_generator_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [23:0] frame_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  status_byte,
  output logic [7:0]  data_one,
  output logic        data_one_present,
  output logic [7:0]  data_two,
  output logic        data_two_present,
  output logic        last_of_run
);
  import msync_pkg::*;

  localparam int PosW = (POSITION_BITS < 24) ? POSITION_BITS : 24;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [1:0] K_CLOCK   = 2'd0;
  localparam logic [1:0] K_QUARTER = 2'd1;
  localparam logic [1:0] K_FULL    = 2'd2;

  logic [1:0]  sync_mode;
  logic [23:0] clock_interval;
  logic [23:0] timecode_interval;
  logic [4:0]  frames_per_second;

  logic [4:0]  tc_frames;
  logic [5:0]  tc_seconds;
  logic [5:0]  tc_minutes;
  logic [4:0]  tc_hours;

  logic [1:0]  state;
  logic [1:0]  kind;
  logic [1:0]  idx;

  logic        div_start;
  logic [23:0] div_divisor;
  div_stat_t   div_stat;

  msg_t        msg;
  msg_t        out_msg;
  logic        load;

  logic [4:0]  frames_inc;
  logic [5:0]  seconds_inc;
  logic [5:0]  minutes_inc;
  logic [4:0]  hours_inc;

  assign in_ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mode         <= '0;
      clock_interval    <= CLOCK_INT_RESET;
      timecode_interval <= TC_INT_RESET;
      frames_per_second <= FPS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYNC_MODE: sync_mode         <= cfg_data[1:0];
        REG_CLOCK_INT: clock_interval    <= cfg_data;
        REG_TC_INT:    timecode_interval <= cfg_data;
        REG_FPS:       frames_per_second <= cfg_data[4:0];
        default:       ;
      endcase
    end
  end

  // remainder of the position by the selected interval
  assign div_start   = in_valid && in_ready && !req_type &&
                       ((sync_mode == MODE_CLOCK && clock_interval != '0) ||
                        (sync_mode == MODE_TIMECODE && timecode_interval != '0));
  assign div_divisor = (sync_mode == MODE_CLOCK) ? clock_interval : timecode_interval;

  msync_mod_serial #(
    .PosW(PosW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (frame_position[PosW-1:0]),
    .divisor  (div_divisor),
    .stat     (div_stat)
  );

  // message for the current kind and piece
  always_comb begin
    msg = '0;
    case (kind)
      K_CLOCK: begin
        msg.status_byte = ST_CLOCK;
        msg.last_of_run = 1'b1;
      end
      K_QUARTER: begin
        msg.status_byte      = ST_QUARTER;
        msg.data_one_present = 1'b1;
        msg.last_of_run      = (idx == 2'd3);
        // piece number is frame parity and index, low nibble the value
        case ({tc_frames[0], idx})
          3'd0:    msg.data_one = {1'b0, 3'd0, tc_frames[3:0]};
          3'd1:    msg.data_one = {1'b0, 3'd1, 3'd0, tc_frames[4]};
          3'd2:    msg.data_one = {1'b0, 3'd2, tc_seconds[3:0]};
          3'd3:    msg.data_one = {1'b0, 3'd3, 2'd0, tc_seconds[5:4]};
          3'd4:    msg.data_one = {1'b0, 3'd4, tc_minutes[3:0]};
          3'd5:    msg.data_one = {1'b0, 3'd5, 2'd0, tc_minutes[5:4]};
          3'd6:    msg.data_one = {1'b0, 3'd6, tc_hours[3:0]};
          default: msg.data_one = {1'b0, 3'd7, 3'd0, tc_hours[4]};
        endcase
      end
      default: begin
        // full-frame sequence
        case (idx)
          2'd0: begin
            msg.status_byte      = ST_SYSEX;
            msg.data_one         = SYSEX_ALL_CALL;
            msg.data_one_present = 1'b1;
            msg.data_two_present = 1'b1;
          end
          2'd1: begin
            msg.status_byte      = SYSEX_MTC;
            msg.data_one         = SYSEX_FULL;
            msg.data_one_present = 1'b1;
            msg.data_two_present = 1'b1;
          end
          2'd2: begin
            msg.data_one_present = 1'b1;
            msg.data_two_present = 1'b1;
          end
          default: begin
            msg.status_byte = ST_EOX;
            msg.last_of_run = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign load = (state == S_EMIT) && (!out_valid || out_ready);

  // counter increments
  assign frames_inc  = tc_frames + 5'd1;
  assign seconds_inc = tc_seconds + 6'd1;
  assign minutes_inc = tc_minutes + 6'd1;
  assign hours_inc   = tc_hours + 5'd1;

  // control sequencer and timecode counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_CLOCK;
      idx        <= '0;
      tc_frames  <= '0;
      tc_seconds <= '0;
      tc_minutes <= '0;
      tc_hours   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_valid) begin
            if (req_type) begin
              tc_frames  <= '0;
              tc_seconds <= '0;
              tc_minutes <= '0;
              tc_hours   <= '0;
              if (sync_mode == MODE_TIMECODE) begin
                kind  <= K_FULL;
                state <= S_EMIT;
              end
            end else if (div_start) begin
              kind  <= (sync_mode == MODE_CLOCK) ? K_CLOCK : K_QUARTER;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= div_stat.rem_zero ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (load) begin
            idx <= idx + 2'd1;
            if (msg.last_of_run) begin
              state <= S_IDLE;
              if (kind == K_QUARTER) begin
                // advance the timecode after the last quarter frame
                if (frames_inc >= frames_per_second) begin
                  tc_frames <= '0;
                  if (seconds_inc >= SECS_PER_MIN) begin
                    tc_seconds <= '0;
                    if (minutes_inc >= MINS_PER_HOUR) begin
                      tc_minutes <= '0;
                      tc_hours   <= (hours_inc >= HOURS_PER_DAY) ? 5'd0 : hours_inc;
                    end else begin
                      tc_minutes <= minutes_inc;
                    end
                  end else begin
                    tc_seconds <= seconds_inc;
                  end
                end else begin
                  tc_frames <= frames_inc;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_msg <= msg;
    end
  end

  assign status_byte      = out_msg.status_byte;
  assign data_one         = out_msg.data_one;
  assign data_one_present = out_msg.data_one_present;
  assign data_two         = out_msg.data_two;
  assign data_two_present = out_msg.data_two_present;
  assign last_of_run      = out_msg.last_of_run;

endmodule

// File: bench/tb_midi_sync_generator_core.sv
`timescale 1ns / 100ps

module tb_midi_sync_generator_core;
  import msync_pkg::*;

  // mode codes the package leaves unnamed
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 100;

  // predicts the midi messages of each request and holds them in order
  class msync_scoreboard;
    msg_t       due_msgs[$];
    logic [1:0] cfg_mode;
    logic [23:0] cfg_clock_int;
    logic [23:0] cfg_tc_int;
    logic [4:0] cfg_fps;
    logic [4:0] frames;
    logic [5:0] secs;
    logic [5:0] mins;
    logic [4:0] hours;
    int         errors;

    function new();
      cfg_mode      = MODE_OFF;
      cfg_clock_int = CLOCK_INT_RESET;
      cfg_tc_int    = TC_INT_RESET;
      cfg_fps       = FPS_RESET;
      frames        = '0;
      secs          = '0;
      mins          = '0;
      hours         = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_SYNC_MODE: cfg_mode = val[1:0];
        REG_CLOCK_INT: cfg_clock_int = val;
        REG_TC_INT:    cfg_tc_int = val;
        REG_FPS:       cfg_fps = val[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_msgs.size();
    endfunction

    // append one predicted message at the tail of the queue
    function void add_due(msg_t m);
      due_msgs.insert(due_msgs.size(), m);
    endfunction

    function msg_t make_msg(logic [7:0] st, logic [7:0] d1, logic p1,
                            logic [7:0] d2, logic p2, logic last);
      msg_t m;
      m.status_byte      = st;
      m.data_one         = d1;
      m.data_one_present = p1;
      m.data_two         = d2;
      m.data_two_present = p2;
      m.last_of_run      = last;
      return m;
    endfunction

    // frame, second, minute, hour carry chain
    function void advance_timecode();
      frames = frames + 5'd1;
      if (frames >= cfg_fps) begin
        frames = '0;
        secs = secs + 6'd1;
        if (secs >= SECS_PER_MIN) begin
          secs = '0;
          mins = mins + 6'd1;
          if (mins >= MINS_PER_HOUR) begin
            mins = '0;
            hours = hours + 5'd1;
            if (hours >= HOURS_PER_DAY) hours = '0;
          end
        end
      end
    endfunction

    // work out the messages caused by one accepted request
    function void predict_messages(logic rewind, logic [23:0] pos);
      logic [3:0] nib [4];
      logic [2:0] base;
      if (rewind) begin
        frames = '0;
        secs   = '0;
        mins   = '0;
        hours  = '0;
        if (cfg_mode == MODE_TIMECODE) begin
          add_due(make_msg(ST_SYSEX, SYSEX_ALL_CALL, 1'b1, 8'h00, 1'b1, 1'b0));
          add_due(make_msg(SYSEX_MTC, SYSEX_FULL, 1'b1, 8'h00, 1'b1, 1'b0));
          add_due(make_msg(8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0));
          add_due(make_msg(ST_EOX, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
        end
      end else if (cfg_mode == MODE_CLOCK) begin
        if (cfg_clock_int != 0 && pos % cfg_clock_int == 0)
          add_due(make_msg(ST_CLOCK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
      end else if (cfg_mode == MODE_TIMECODE) begin
        if (cfg_tc_int != 0 && pos % cfg_tc_int == 0) begin
          // even frames carry frames and seconds, odd ones minutes and hours
          if (!frames[0]) begin
            base   = 3'd0;
            nib[0] = frames[3:0];
            nib[1] = {3'b000, frames[4]};
            nib[2] = secs[3:0];
            nib[3] = {2'b00, secs[5:4]};
          end else begin
            base   = 3'd4;
            nib[0] = mins[3:0];
            nib[1] = {2'b00, mins[5:4]};
            nib[2] = hours[3:0];
            nib[3] = {3'b000, hours[4]};
          end
          for (int k = 0; k < 4; k++)
            add_due(make_msg(ST_QUARTER, {1'b0, base + 3'(k), nib[k]}, 1'b1,
                             8'h00, 1'b0, k == 3));
          advance_timecode();
        end
      end
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTS) $display("mismatch: %s", what);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // compare one output transfer with the oldest predicted message
    task check_message(msg_t got);
      msg_t want;
      if (due_msgs.size() == 0) begin
        report_mismatch($sformatf("unexpected message %h %h %h", got.status_byte,
                                  got.data_one, got.data_two));
      end else begin
        want = due_msgs.pop_front();
        compare_field("status_byte", got.status_byte, want.status_byte);
        compare_field("data_one", got.data_one, want.data_one);
        compare_field("data_one_present", got.data_one_present, want.data_one_present);
        compare_field("data_two", got.data_two, want.data_two);
        compare_field("data_two_present", got.data_two_present, want.data_two_present);
        compare_field("last_of_run", got.last_of_run, want.last_of_run);
      end
    endtask

    task flush_leftovers();
      msg_t want;
      while (due_msgs.size() != 0) begin
        want = due_msgs.pop_front();
        report_mismatch($sformatf("message %h %h never arrived", want.status_byte,
                                  want.data_one));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [23:0] frame_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  status_byte;
  logic [7:0]  data_one;
  logic        data_one_present;
  logic [7:0]  data_two;
  logic        data_two_present;
  logic        last_of_run;

  msync_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  midi_sync_generator_core u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .frame_position   (frame_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status_byte      (status_byte),
    .data_one         (data_one),
    .data_one_present (data_one_present),
    .data_two         (data_two),
    .data_two_present (data_two_present),
    .last_of_run      (last_of_run)
  );

  always #5 clk = ~clk;

  // output side: random stalls and checking of each transfer
  always @(posedge clk) begin
    msg_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.status_byte      = status_byte;
      got.data_one         = data_one;
      got.data_one_present = data_one_present;
      got.data_two         = data_two;
      got.data_two_present = data_two_present;
      got.last_of_run      = last_of_run;
      sb.check_message(got);
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_midi_sync_generator_core failed");
      $finish;
    end
  end

  // one request transfer, with a random gap ahead of it
  task automatic send_item(logic rewind, logic [23:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= rewind;
    frame_position <= pos;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.predict_messages(rewind, pos);
  endtask

  // idle the input until all messages are out, plus the block latency
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender holds off until every predicted message has arrived
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // write all four registers while the block is idle
  task automatic configure(logic [1:0] mode, logic [23:0] cint, logic [23:0] tint,
                           logic [4:0] fps);
    logic [1:0]  regs [4];
    logic [23:0] vals [4];
    regs = '{REG_SYNC_MODE, REG_CLOCK_INT, REG_TC_INT, REG_FPS};
    vals = '{{22'd0, mode}, cint, tint, {19'd0, fps}};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.write_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // mostly positions on the interval grid, some rewinds and noise
  task automatic run_items(int n);
    int unsigned iv;
    int unsigned k;
    int unsigned pick;
    logic [23:0] pos;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) hold_until_drained();
      pick = $urandom_range(99);
      iv   = (sb.cfg_mode == MODE_CLOCK) ? sb.cfg_clock_int : sb.cfg_tc_int;
      if (pick < 10) begin
        send_item(1'b1, 24'($urandom));
      end else if (pick < 75 && iv != 0) begin
        k   = $urandom_range(0, 24'hFFFFFF / iv);
        pos = 24'(k * iv);
        send_item(1'b0, pos);
      end else begin
        send_item(1'b0, 24'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, sync off
    send_item(1'b0, 24'h000000);
    send_item(1'b1, 24'hFFFFFF);

    // clock mode at both interval extremes
    configure(MODE_CLOCK, 24'd1, TC_INT_RESET, FPS_RESET);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b1, 24'h000000);
    configure(MODE_CLOCK, 24'hFFFFFF, TC_INT_RESET, FPS_RESET);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'hFFFFFE);

    // zero clock interval never matches
    configure(MODE_CLOCK, 24'd0, TC_INT_RESET, FPS_RESET);
    send_item(1'b0, 24'h000000);

    // timecode with full-frame rewind and frame rate thirty-one
    configure(MODE_TIMECODE, 24'd1, 24'd1, 5'd31);
    send_item(1'b1, 24'h000000);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h555555);
    send_item(1'b0, 24'hAAAAAA);

    // frame rate zero: seconds advance every frame
    configure(MODE_TIMECODE, 24'd1, 24'hFFFFFF, 5'd0);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'h000005);
    send_item(1'b0, 24'hFFFFFF);

    // zero timecode interval never matches
    configure(MODE_TIMECODE, 24'd1, 24'd0, FPS_RESET);
    send_item(1'b0, 24'h000000);

    // mode three emits nothing but a rewind still clears the counters
    configure(MODE_UNUSED, 24'd1, 24'd1, 5'd1);
    send_item(1'b0, 24'h000000);
    send_item(1'b1, 24'h000000);
    configure(MODE_TIMECODE, 24'd1, 24'd1, 5'd1);
    send_item(1'b0, 24'h000001);
    send_item(1'b0, 24'h000002);

    // random phases over three idle profiles
    for (int ph = 0; ph < 12; ph++) begin
      logic [1:0]  mode;
      logic [23:0] cint;
      logic [23:0] tint;
      logic [4:0]  fps;
      send_idle_pct = (ph < 4) ? 30 : (ph < 8) ? 70 : 0;
      recv_idle_pct = (ph < 4) ? 70 : (ph < 8) ? 30 : 0;
      case (ph % 4)
        0, 2:    mode = MODE_TIMECODE;
        1:       mode = MODE_CLOCK;
        default: mode = 2'($urandom_range(0, 3));
      endcase
      cint = (ph % 3 == 2) ? 24'($urandom_range(1, 24'hFFFFFF)) : 24'($urandom_range(1, 6));
      tint = (ph % 3 == 1) ? 24'($urandom_range(1, 24'hFFFFFF)) : 24'($urandom_range(1, 6));
      fps  = 5'($urandom_range(1, 30));
      if (ph == 5) begin
        cint = 24'hFFFFFF;
        tint = 24'hFFFFFF;
      end
      if (ph == 7) fps = 5'd0;
      if (ph == 10) fps = 5'd31;
      configure(mode, cint, tint, fps);
      run_items(24);
    end

    // long timecode run so seconds carry into minutes
    configure(MODE_TIMECODE, 24'd1, 24'd1, 5'd2);
    send_item(1'b1, 24'h000000);
    for (int i = 0; i < 124; i++) send_item(1'b0, 24'($urandom));

    // drain, then final verdict
    settle();
    sb.flush_leftovers();
    if (sb.errors == 0)
      $display("tb_midi_sync_generator_core passed");
    else
      $display("tb_midi_sync_generator_core failed");
    $finish;
  end

endmodule
